@@ sv/wcid_pkg.sv @@
package wcid_pkg;

    localparam int WORD_W    = 64;
    localparam int POS_W     = 32;
    localparam int WIN_W     = 16;
    localparam int TAIL_W    = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 184;

    localparam logic [TAIL_W-1:0]    TAIL_MAX     = 17'h1FFFF;
    localparam logic [WIN_W-1:0]     WINDOW_RESET = 16'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WORDS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POSITION = 1'b1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [POS_W-1:0]  word_position;
        logic              close;
        logic [POS_W-1:0]  run_begin;
        logic [POS_W-1:0]  run_finish;
        logic [TAIL_W-1:0] drop_count;
    } t_pair;

endpackage

@@ sv/windowed_change_interval_diff.sv @@
// A taken word is registered, then pushed into the output register once that is
// free. Throughput: one input word per cycle unless the output or remainder
// stalls; a word that closes a run yields two output words and holds the input
// side until its close word is taken. Writing first_position starts a remainder
// by BLOCK_WORDS; input words wait until it finishes. Synchronous active-low
// reset clears all control state, window_words to 8 and first_position to 0.
module windowed_change_interval_diff #(
    parameter int BLOCK_WORDS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [wcid_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // new_word, old_word
    input  logic                                s_axis_tlast,  // stream_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // data_word, word_position, run_begin, run_finish, drop_count, pad
    output logic [wcid_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,  // item_kind
    output logic                                m_axis_tlast,  // final_item
    input  logic                                i_cfg_we,
    input  logic [wcid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wcid_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int BOFF_W = $clog2(BLOCK_WORDS + 1);

    logic              rem_start;
    logic              rem_busy;
    logic              rem_done;
    logic [BOFF_W-1:0] rem;
    logic              pair_free;
    logic              push;
    wcid_pkg::t_pair   pair;

    assign rem_start = i_cfg_we && i_cfg_index == wcid_pkg::CFG_FIRST_POSITION;

    wcid_divrem #(
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_divrem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (i_cfg_data),
        .o_busy  (rem_busy),
        .o_done  (rem_done),
        .o_rem   (rem)
    );

    wcid_core #(
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_new_word   (s_axis_tdata[wcid_pkg::WORD_W-1:0]),
        .i_old_word   (s_axis_tdata[2*wcid_pkg::WORD_W-1:wcid_pkg::WORD_W]),
        .i_stream_end (s_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rem_busy   (rem_busy),
        .i_rem_done   (rem_done),
        .i_rem        (rem),
        .i_pair_free  (pair_free),
        .o_push       (push),
        .o_pair       (pair)
    );

    wcid_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pair   (pair),
        .o_free   (pair_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

@@ sv/wcid_divrem.sv @@
module wcid_divrem #(
    parameter int BLOCK_WORDS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [wcid_pkg::POS_W-1:0]             i_value,
    output logic                                   o_busy,
    output logic                                   o_done,
    output logic [$clog2(BLOCK_WORDS+1)-1:0]       o_rem
);

    localparam int BOFF_W  = $clog2(BLOCK_WORDS + 1);
    localparam int SHIFT   = wcid_pkg::POS_W + $clog2(BLOCK_WORDS);
    localparam int RECIP_W = wcid_pkg::POS_W + 1;
    localparam int PROD_W  = wcid_pkg::POS_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BLOCK_WORDS) - 64'd1) / 64'(BLOCK_WORDS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic                       r_mul_v;
    logic                       r_sub_v;
    logic                       r_done;
    logic [wcid_pkg::POS_W-1:0] r_val;
    logic [PROD_W-1:0]          r_prod;
    logic [BOFF_W-1:0]          r_rem;
    logic [wcid_pkg::POS_W-1:0] n_quot;
    logic [wcid_pkg::POS_W-1:0] n_rem;

    // remainder by reciprocal multiplication: multiply, then subtract
    always_comb begin
        n_quot = wcid_pkg::POS_W'(r_prod >> SHIFT);
        n_rem  = r_val - n_quot * wcid_pkg::POS_W'(BLOCK_WORDS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_sub_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_mul_v <= i_start;
            r_sub_v <= r_mul_v && !i_start;
            r_done  <= r_sub_v && !i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_mul_v) begin
            r_prod <= PROD_W'(r_val) * PROD_W'(RECIP);
        end
        if (r_sub_v) begin
            r_rem <= n_rem[BOFF_W-1:0];
        end
    end

    assign o_busy = r_mul_v || r_sub_v;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ sv/wcid_core.sv @@
module wcid_core #(
    parameter int BLOCK_WORDS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [wcid_pkg::WORD_W-1:0]         i_new_word,
    input  logic [wcid_pkg::WORD_W-1:0]         i_old_word,
    input  logic                                i_stream_end,
    input  logic                                i_cfg_we,
    input  logic [wcid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wcid_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_rem_busy,
    input  logic                                i_rem_done,
    input  logic [$clog2(BLOCK_WORDS+1)-1:0]    i_rem,
    input  logic                                i_pair_free,
    output logic                                o_push,
    output wcid_pkg::t_pair                     o_pair
);

    localparam int BOFF_W = $clog2(BLOCK_WORDS + 1);
    localparam logic [BOFF_W-1:0] LAST_OFF = BOFF_W'(BLOCK_WORDS - 1);

    logic                         r_in_v;
    logic [wcid_pkg::WORD_W-1:0]  r_in_new;
    logic [wcid_pkg::WORD_W-1:0]  r_in_old;
    logic                         r_in_last;

    logic [wcid_pkg::WIN_W-1:0]   r_window;
    logic [wcid_pkg::POS_W-1:0]   r_first;
    logic [BOFF_W-1:0]            r_first_off;
    logic                         r_open;
    logic [wcid_pkg::POS_W-1:0]   r_wc;
    logic [BOFF_W-1:0]            r_boff;
    logic [wcid_pkg::POS_W-1:0]   r_start;
    logic [wcid_pkg::TAIL_W-1:0]  r_tail;
    logic                         r_isb;

    logic                         advance;
    logic                         changed;
    logic                         block_end;
    logic                         close;
    logic [wcid_pkg::POS_W-1:0]   next_pos;
    logic                         n_open;
    logic [wcid_pkg::POS_W-1:0]   n_start;
    logic [wcid_pkg::TAIL_W-1:0]  n_tail;
    logic                         n_isb;

    assign advance = r_in_v && i_pair_free && !i_rem_busy && !i_rem_done;
    assign o_ready = !r_in_v || advance;

    always_comb begin
        changed   = r_in_new != r_in_old;
        next_pos  = r_wc + 1'b1;
        // the counter wrapping to zero also ends a block
        block_end = (r_boff == LAST_OFF) || (&r_wc);
        n_open    = r_open;
        n_start   = r_start;
        n_tail    = r_tail;
        n_isb     = r_isb;
        close     = 1'b0;
        if (!r_open && changed) begin
            n_open  = 1'b1;
            n_start = r_wc;
            n_tail  = '0;
            n_isb   = 1'b1;
        end else if (r_open) begin
            if (changed) begin
                n_tail = '0;
            end else if (r_tail != wcid_pkg::TAIL_MAX) begin
                n_tail = r_tail + 1'b1;
            end
        end
        if (n_open) begin
            if (block_end) begin
                if (n_isb) begin
                    n_isb = 1'b0;
                end else if (n_tail > wcid_pkg::TAIL_W'(r_window)) begin
                    close = 1'b1;
                end
            end
            if (r_in_last) begin
                close = 1'b1;
            end
        end
        o_push                = advance && n_open;
        o_pair.data_word      = r_in_new;
        o_pair.word_position  = r_wc;
        o_pair.close          = close;
        o_pair.run_begin      = n_start;
        o_pair.run_finish     = next_pos - wcid_pkg::POS_W'(n_tail);
        o_pair.drop_count     = n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_new  <= i_new_word;
            r_in_old  <= i_old_word;
            r_in_last <= i_stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= wcid_pkg::WINDOW_RESET;
            r_first     <= '0;
            r_first_off <= '0;
            r_open      <= 1'b0;
            r_wc        <= '0;
            r_boff      <= '0;
            r_start     <= '0;
            r_tail      <= '0;
            r_isb       <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == wcid_pkg::CFG_WINDOW_WORDS) begin
                r_window <= i_cfg_data[wcid_pkg::WIN_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == wcid_pkg::CFG_FIRST_POSITION) begin
                r_first <= i_cfg_data;
                r_wc    <= i_cfg_data;
            end
            if (i_rem_done) begin
                r_first_off <= i_rem;
                r_boff      <= i_rem;
            end
            if (advance) begin
                r_start <= n_start;
                if (close || r_in_last) begin
                    r_open <= 1'b0;
                    r_tail <= '0;
                    r_isb  <= 1'b0;
                end else begin
                    r_open <= n_open;
                    r_tail <= n_tail;
                    r_isb  <= n_isb;
                end
                if (r_in_last) begin
                    r_wc   <= r_first;
                    r_boff <= r_first_off;
                end else begin
                    r_wc   <= next_pos;
                    r_boff <= block_end ? '0 : r_boff + 1'b1;
                end
            end
        end
    end

endmodule

@@ sv/wcid_out.sv @@
module wcid_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  wcid_pkg::t_pair                 i_pair,
    output logic                            o_free,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [wcid_pkg::M_TDATA_W-1:0]  o_tdata,
    output logic                            o_tuser,
    output logic                            o_tlast
);

    typedef enum logic {PH_DATA, PH_CLOSE} t_phase;

    t_phase          r_phase;
    logic            r_pv;
    wcid_pkg::t_pair r_pair;
    logic            fire;
    logic            word_last;

    assign word_last = (r_phase == PH_CLOSE) || !r_pair.close;
    assign fire      = r_pv && i_tready;
    assign o_free    = !r_pv || (i_tready && word_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_phase <= PH_DATA;
        end else if (i_push) begin
            r_pv    <= 1'b1;
            r_phase <= PH_DATA;
        end else if (fire) begin
            if (word_last) begin
                r_pv    <= 1'b0;
                r_phase <= PH_DATA;
            end else begin
                r_phase <= PH_CLOSE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pair <= i_pair;
        end
    end

    always_comb begin
        o_tvalid = r_pv;
        o_tlast  = word_last;
        case (r_phase)
            PH_DATA: begin
                o_tuser = wcid_pkg::KIND_DATA;
                o_tdata = {7'b0, wcid_pkg::TAIL_W'(0), 64'b0,
                           r_pair.word_position, r_pair.data_word};
            end
            PH_CLOSE: begin
                o_tuser = wcid_pkg::KIND_CLOSE;
                o_tdata = {7'b0, r_pair.drop_count, r_pair.run_finish,
                           r_pair.run_begin, 96'b0};
            end
            default: begin
                o_tuser = wcid_pkg::KIND_DATA;
                o_tdata = '0;
            end
        endcase
    end

endmodule

@@ sv/wcid_checker.sv @@
module wcid_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [wcid_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tuser,
    input  logic                            m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == wcid_pkg::KIND_CLOSE |-> m_axis_tlast)
        else $error("close record not last of its input");

    a_close_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == wcid_pkg::KIND_DATA
        && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser == wcid_pkg::KIND_CLOSE)
        else $error("close record missing after data word");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == wcid_pkg::KIND_DATA
        |-> m_axis_tdata[wcid_pkg::M_TDATA_W-1:96] == '0)
        else $error("data word carries close fields");

endmodule

bind windowed_change_interval_diff wcid_checker u_wcid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/windowed_change_interval_diff_checker.sv @@
`timescale 1ns / 100ps

module windowed_change_interval_diff_checker
    import wcid_pkg::*;
#(
    parameter int BLOCK_WORDS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // new_word, old_word
    input  logic                 i_s_tlast,   // stream_end
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // data_word, word_position, run_begin, run_finish, drop_count, pad
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_m_tuser,   // item_kind
    input  logic                 i_m_tlast,   // final_item
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    localparam int POS_LSB  = WORD_W;
    localparam int BEG_LSB  = POS_LSB + POS_W;
    localparam int FIN_LSB  = BEG_LSB + POS_W;
    localparam int DROP_LSB = FIN_LSB + POS_W;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  rbegin;
        logic [POS_W-1:0]  rfinish;
        logic [TAIL_W-1:0] drop;
        logic              fin;
    } t_run_word;

    t_run_word         run_words_q[$];
    int                mismatches = 0;

    logic [WIN_W-1:0]  window_words;
    logic [POS_W-1:0]  first_pos;
    logic              run_open;
    logic [POS_W-1:0]  word_ctr;
    logic [POS_W-1:0]  open_start;
    logic [TAIL_W-1:0] tail;
    logic              start_blk;

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_run_word();
        t_run_word want;
        if (run_words_q.size() == 0) begin
            $error("unexpected output word: kind %0d, data 0x%0h", i_m_tuser,
                   i_m_tdata[WORD_W-1:0]);
            mismatches++;
        end else begin
            want = run_words_q.pop_front();
            cmp_field("item_kind", 64'(want.kind), 64'(i_m_tuser));
            cmp_field("data_word", want.data, i_m_tdata[WORD_W-1:0]);
            cmp_field("word_position", 64'(want.pos), 64'(i_m_tdata[POS_LSB +: POS_W]));
            cmp_field("run_begin", 64'(want.rbegin), 64'(i_m_tdata[BEG_LSB +: POS_W]));
            cmp_field("run_finish", 64'(want.rfinish), 64'(i_m_tdata[FIN_LSB +: POS_W]));
            cmp_field("drop_count", 64'(want.drop), 64'(i_m_tdata[DROP_LSB +: TAIL_W]));
            cmp_field("final_item", 64'(want.fin), 64'(i_m_tlast));
        end
    endtask

    task automatic predict_run_words(input logic [WORD_W-1:0] nw,
                                     input logic [WORD_W-1:0] ow, input logic last);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] nxt;
        logic             changed;
        logic             blk_end;
        logic             do_close;
        t_run_word        w;
        pos      = word_ctr;
        nxt      = pos + 1'b1;
        changed  = nw != ow;
        blk_end  = (nxt % BLOCK_WORDS) == 0;
        do_close = 1'b0;

        if (!run_open && changed) begin
            run_open   = 1'b1;
            open_start = pos;
            tail       = '0;
            start_blk  = 1'b1;
        end else if (run_open) begin
            if (changed) begin
                tail = '0;
            end else if (tail != TAIL_MAX) begin
                tail = tail + 1'b1;
            end
        end

        if (run_open) begin
            if (blk_end) begin
                if (start_blk) begin
                    start_blk = 1'b0;
                end else if (tail > {1'b0, window_words}) begin
                    do_close = 1'b1;
                end
            end
            if (last) begin
                do_close = 1'b1;
            end
            w      = '0;
            w.kind = KIND_DATA;
            w.data = nw;
            w.pos  = pos;
            w.fin  = !do_close;
            run_words_q.push_back(w);
        end

        if (do_close) begin
            w         = '0;
            w.kind    = KIND_CLOSE;
            w.rbegin  = open_start;
            w.rfinish = nxt - POS_W'(tail);
            w.drop    = tail;
            w.fin     = 1'b1;
            run_words_q.push_back(w);
            run_open  = 1'b0;
            tail      = '0;
            start_blk = 1'b0;
        end

        if (last) begin
            run_open  = 1'b0;
            tail      = '0;
            start_blk = 1'b0;
            word_ctr  = first_pos;
        end else begin
            word_ctr = nxt;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_words = WINDOW_RESET;
            first_pos    = '0;
            run_open     = 1'b0;
            word_ctr     = '0;
            open_start   = '0;
            tail         = '0;
            start_blk    = 1'b0;
            run_words_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_WORDS: begin
                        window_words = i_cfg_data[WIN_W-1:0];
                    end
                    CFG_FIRST_POSITION: begin
                        first_pos = i_cfg_data[POS_W-1:0];
                        word_ctr  = i_cfg_data[POS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                check_run_word();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_run_words(i_s_tdata[WORD_W-1:0], i_s_tdata[WORD_W +: WORD_W],
                                  i_s_tlast);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= run_words_q.size();
    end

endmodule

@@ tb/sv/tb_windowed_change_interval_diff.sv @@
`timescale 1ns / 100ps

module tb_windowed_change_interval_diff;
    import wcid_pkg::*;

    localparam int BLOCK_WORDS  = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 8;
    localparam int RANDOM_WORDS = 900;
    localparam int QUIET_WORDS  = 150;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // new_word, old_word
    logic                 s_axis_tlast;   // stream_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // data_word, word_position, run_begin, run_finish, drop_count, pad
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;   // item_kind
    logic                 m_axis_tlast;   // final_item
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int                   mismatches;
    int                   pending;
    int                   words_sent = 0;
    int                   cycle_count = 0;
    int                   quiet_start = CYCLE_LIMIT;
    logic                 idle_on = 1'b0;

    windowed_change_interval_diff #(
        .BLOCK_WORDS(BLOCK_WORDS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    windowed_change_interval_diff_checker #(
        .BLOCK_WORDS(BLOCK_WORDS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_windowed_change_interval_diff: FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts while idling is on
    initial begin : receiver
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 17);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] nw, input logic [WORD_W-1:0] ow,
                             input logic last);
        int gap;
        if (words_sent >= quiet_start) begin
            idle_on = 1'b0;
        end
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ow, nw};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] differing(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] o;
        case ($urandom_range(0, 2))
            0:       o = ~w;
            1:       o = w ^ (64'd1 << $urandom_range(0, 63));
            default: o = {$urandom, $urandom};
        endcase
        if (o == w) begin
            o = w ^ 64'd1;
        end
        return o;
    endfunction

    // changes come in clusters so that runs open, grow tails and close
    task automatic send_buffer(input int len, input logic with_end);
        logic [WORD_W-1:0] nw;
        logic              burst;
        logic              chg;
        burst = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                burst = !burst;
            end
            chg = burst ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 11) == 0);
            nw  = rand_word();
            send_word(nw, chg ? differing(nw) : nw, with_end && (k == len - 1));
        end
    endtask

    initial begin : stimulus
        logic [WORD_W-1:0] r;
        logic [CFG_W-1:0]  fp;
        logic [WIN_W-1:0]  win;
        int                len;
        int                total;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_WINDOW_WORDS;
        i_cfg_data    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, unchanged word ending a stream
        send_word('1, '1, 1'b1);
        wait_idle();

        // misaligned start, run opened on a block end, tail close at next block end
        write_reg(CFG_WINDOW_WORDS, CFG_W'(0));
        write_reg(CFG_FIRST_POSITION, CFG_W'(7));
        send_word('1, '0, 1'b0);
        send_word('0, '1, 1'b0);
        repeat (7) begin
            r = {$urandom, $urandom};
            send_word(r, r, 1'b0);
        end
        // run begun and closed by the final word, then stream end with no run
        r = {$urandom, $urandom};
        send_word(r, ~r, 1'b1);
        send_word('0, '0, 1'b1);
        wait_idle();

        // widest window, position counter wrapping past 2^32
        write_reg(CFG_WINDOW_WORDS, CFG_W'(16'hFFFF));
        write_reg(CFG_FIRST_POSITION, 32'hFFFF_FFFE);
        r = {$urandom, $urandom};
        send_word(r, ~r, 1'b0);
        send_word(r, r, 1'b0);
        send_word(r, r, 1'b0);
        send_word(r, r, 1'b1);

        total = words_sent + RANDOM_WORDS;
        quiet_start = total - QUIET_WORDS;
        while (words_sent < total) begin
            wait_idle();
            idle_on = (words_sent < total - QUIET_WORDS) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 6))
                    0:       win = '0;
                    1:       win = '1;
                    2:       win = WIN_W'($urandom);
                    3:       win = WIN_W'($urandom_range(5, 16));
                    default: win = WIN_W'($urandom_range(1, 4));
                endcase
                write_reg(CFG_WINDOW_WORDS, CFG_W'(win));
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0:       fp = '0;
                    1:       fp = 32'hFFFF_FFF8;
                    2:       fp = {29'($urandom_range(0, 32'h1FFF_FFFF)), 3'b000};
                    3:       fp = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                    default: fp = $urandom;
                endcase
                write_reg(CFG_FIRST_POSITION, fp);
            end
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 48);
                send_buffer(len, $urandom_range(0, 7) != 0);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_windowed_change_interval_diff: PASS");
        end else begin
            $display("tb_windowed_change_interval_diff: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/wcid_pkg.sv
sv/wcid_divrem.sv
sv/wcid_core.sv
sv/wcid_out.sv
sv/windowed_change_interval_diff.sv
sv/wcid_checker.sv
tb/sv/windowed_change_interval_diff_checker.sv
tb/sv/tb_windowed_change_interval_diff.sv
